[rtl/mcd_pkg.sv]
// ----------------------------------------------------------------------------
// mcd_pkg
// Shared types and constants of the masked centroid and depth block: word
// layouts of both channels, register indexes, division selects and the
// command group from the controller to the datapath.
// ----------------------------------------------------------------------------
package mcd_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int DEPTH_BITS_DEF = 16;

  localparam int CNT_W = 20;
  localparam int CXY_W = 14;
  localparam int DEP_W = 16;
  localparam int POS_W = 10;
  localparam int EXT_W = 24;
  localparam int CFG_IDX_W = 1;
  localparam int SEL_W = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] OBJECT_MIN_RST = CNT_W'(20);
  localparam logic [CNT_W-1:0] HAND_MIN_RST = CNT_W'(50);

  localparam logic [CFG_IDX_W-1:0] REG_OBJECT_MIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HAND_MIN = 1'd1;

  localparam logic [SEL_W-1:0] SEL_HAND_X = 3'd0;
  localparam logic [SEL_W-1:0] SEL_HAND_Y = 3'd1;
  localparam logic [SEL_W-1:0] SEL_HAND_D = 3'd2;
  localparam logic [SEL_W-1:0] SEL_OBJ_X = 3'd3;
  localparam logic [SEL_W-1:0] SEL_OBJ_Y = 3'd4;
  localparam logic [SEL_W-1:0] SEL_OBJ_D = 3'd5;

  typedef struct packed {
    logic             hand_bit;
    logic             object_bit;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [DEP_W-1:0] depth_mm;
    logic             frame_first;
    logic             frame_last;
  } pixel_t;

  typedef struct packed {
    logic             hand_found;
    logic [CXY_W-1:0] hand_cx;
    logic [CXY_W-1:0] hand_cy;
    logic [DEP_W-1:0] hand_depth;
    logic             object_found;
    logic [CXY_W-1:0] object_cx;
    logic [CXY_W-1:0] object_cy;
    logic [DEP_W-1:0] object_depth;
  } result_t;

  typedef struct packed {
    logic             acc_en;
    logic             div_start;
    logic             div_step;
    logic [SEL_W-1:0] div_sel;
    logic             result_store;
    logic             out_load;
  } cmd_t;

endpackage

[rtl/mcd_ctrl.sv]
// ----------------------------------------------------------------------------
// mcd_ctrl
// Controller: takes pixels while accumulating, then sequences the six
// divisions of a frame result and hands the result to the output register.
// ----------------------------------------------------------------------------
module mcd_ctrl #(
  parameter int COORD_BITS = mcd_pkg::COORD_BITS_DEF,
  parameter int DEPTH_BITS = mcd_pkg::DEPTH_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_last_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mcd_pkg::cmd_t cmd_o
);
  import mcd_pkg::*;

  localparam int DW = (COORD_BITS + 24 > DEPTH_BITS + 20) ? COORD_BITS + 24 : DEPTH_BITS + 20;
  localparam int SW = $clog2(DW);

  localparam logic [2:0] ST_ACC   = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_STEP  = 3'd2;
  localparam logic [2:0] ST_STORE = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [SW-1:0]    step_q, step_d;
  logic [SEL_W-1:0] sel_q, sel_d;
  logic             out_valid_q, out_valid_d;
  logic             in_acc;
  logic             out_free;

  assign in_stall_o = (state_q != ST_ACC);
  assign in_acc = in_valid_i && (state_q == ST_ACC);
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    step_d = step_q;
    sel_d = sel_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o = '0;
    cmd_o.div_sel = sel_q;
    case (state_q)
      ST_ACC: begin
        cmd_o.acc_en = in_acc;
        if (in_acc && in_last_i) begin
          sel_d = SEL_HAND_X;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.div_start = 1'b1;
        step_d = '0;
        state_d = ST_STEP;
      end
      ST_STEP: begin
        cmd_o.div_step = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == SW'(DW - 1)) begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd_o.result_store = 1'b1;
        if (sel_q == SEL_OBJ_D) begin
          state_d = ST_DONE;
        end else begin
          sel_d = sel_q + 1'b1;
          state_d = ST_LOAD;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d = 1'b1;
          state_d = ST_ACC;
        end
      end
      default: begin
        state_d = ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACC;
      step_q <= '0;
      sel_q <= SEL_HAND_X;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q <= step_d;
      sel_q <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_last_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_last_i) |=> (state_q == ST_LOAD && sel_q == SEL_HAND_X))
    else $error("frame end did not start the division sequence");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) |-> (step_q <= SW'(DW - 1)))
    else $error("division step count out of range");

  a_sel_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q <= SEL_OBJ_D)
    else $error("division select out of range");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a pending word");

  a_no_acc_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.div_step || cmd_o.div_start) |-> !cmd_o.acc_en)
    else $error("pixel taken during division");

endmodule

[rtl/mcd_datapath.sv]
// ----------------------------------------------------------------------------
// mcd_datapath
// Datapath: threshold registers, per-class accumulators, a shared
// restoring divider, held centroids and the output word register.
// ----------------------------------------------------------------------------
module mcd_datapath #(
  parameter int COORD_BITS = mcd_pkg::COORD_BITS_DEF,
  parameter int DEPTH_BITS = mcd_pkg::DEPTH_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mcd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mcd_pkg::CNT_W-1:0]         cfg_data_i,
  input  mcd_pkg::pixel_t                   in_word_i,
  input  mcd_pkg::cmd_t                     cmd_i,
  output mcd_pkg::result_t                  out_word_o
);
  import mcd_pkg::*;

  localparam int SX = COORD_BITS + CNT_W;
  localparam int SD = DEPTH_BITS + CNT_W;
  localparam int DW = (COORD_BITS + 24 > DEPTH_BITS + 20) ? COORD_BITS + 24 : DEPTH_BITS + 20;

  logic [CNT_W-1:0] obj_min_q, hand_min_q;
  logic [CNT_W-1:0] h_cnt_q, h_cnt_d, o_cnt_q, o_cnt_d;
  logic [SX-1:0]    h_sx_q, h_sx_d, h_sy_q, h_sy_d, o_sx_q, o_sx_d, o_sy_q, o_sy_d;
  logic [SD-1:0]    h_sd_q, h_sd_d, o_sd_q, o_sd_d;
  logic [EXT_W-1:0] x_ext, y_ext, d_ext;
  logic [COORD_BITS-1:0] px, py;
  logic [DEPTH_BITS-1:0] pd;
  logic             is_obj, is_hand;
  logic             hand_found, obj_found;

  logic [DW-1:0]    dq_q, dq_d, dividend;
  logic [CNT_W-1:0] rem_q, rem_d, dvs_q, dvs_d, divisor;
  logic [CNT_W:0]   trial, diff;

  logic [CXY_W-1:0] hcx_q, hcy_q, ocx_q, ocy_q;
  logic [DEP_W-1:0] hd_q, od_q;
  result_t          out_q;

  assign x_ext = EXT_W'(in_word_i.pos_x);
  assign y_ext = EXT_W'(in_word_i.pos_y);
  assign d_ext = EXT_W'(in_word_i.depth_mm);
  assign px = x_ext[COORD_BITS-1:0];
  assign py = y_ext[COORD_BITS-1:0];
  assign pd = d_ext[DEPTH_BITS-1:0];
  assign is_obj = in_word_i.object_bit;
  assign is_hand = in_word_i.hand_bit && !in_word_i.object_bit;

  assign hand_found = h_cnt_q > hand_min_q;
  assign obj_found = o_cnt_q > obj_min_q;

  // accumulate, with restart on frame first and clear once the result is out
  always_comb begin
    h_cnt_d = h_cnt_q;
    h_sx_d = h_sx_q;
    h_sy_d = h_sy_q;
    h_sd_d = h_sd_q;
    o_cnt_d = o_cnt_q;
    o_sx_d = o_sx_q;
    o_sy_d = o_sy_q;
    o_sd_d = o_sd_q;
    if (cmd_i.acc_en) begin
      if (in_word_i.frame_first) begin
        h_cnt_d = '0;
        h_sx_d = '0;
        h_sy_d = '0;
        h_sd_d = '0;
        o_cnt_d = '0;
        o_sx_d = '0;
        o_sy_d = '0;
        o_sd_d = '0;
      end
      if (is_hand && h_cnt_d != CNT_MAX) begin
        h_cnt_d = h_cnt_d + 1'b1;
        h_sx_d = h_sx_d + SX'(px);
        h_sy_d = h_sy_d + SX'(py);
        h_sd_d = h_sd_d + SD'(pd);
      end
      if (is_obj && o_cnt_d != CNT_MAX) begin
        o_cnt_d = o_cnt_d + 1'b1;
        o_sx_d = o_sx_d + SX'(px);
        o_sy_d = o_sy_d + SX'(py);
        o_sd_d = o_sd_d + SD'(pd);
      end
    end
    if (cmd_i.out_load) begin
      h_cnt_d = '0;
      h_sx_d = '0;
      h_sy_d = '0;
      h_sd_d = '0;
      o_cnt_d = '0;
      o_sx_d = '0;
      o_sy_d = '0;
      o_sd_d = '0;
    end
  end

  always_comb begin
    dividend = '0;
    case (cmd_i.div_sel)
      SEL_HAND_X: dividend = DW'({h_sx_q, 4'b0000});
      SEL_HAND_Y: dividend = DW'({h_sy_q, 4'b0000});
      SEL_HAND_D: dividend = DW'(h_sd_q);
      SEL_OBJ_X:  dividend = DW'({o_sx_q, 4'b0000});
      SEL_OBJ_Y:  dividend = DW'({o_sy_q, 4'b0000});
      SEL_OBJ_D:  dividend = DW'(o_sd_q);
      default:    dividend = '0;
    endcase
    divisor = (cmd_i.div_sel inside {SEL_HAND_X, SEL_HAND_Y, SEL_HAND_D}) ? h_cnt_q : o_cnt_q;
  end

  // restoring division, one quotient bit a cycle
  assign trial = {rem_q, dq_q[DW-1]};
  assign diff = trial - {1'b0, dvs_q};

  always_comb begin
    dq_d = dq_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    if (cmd_i.div_start) begin
      dq_d = dividend;
      rem_d = '0;
      dvs_d = divisor;
    end else if (cmd_i.div_step) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[CNT_W-1:0];
        dq_d = {dq_q[DW-2:0], 1'b1};
      end else begin
        rem_d = trial[CNT_W-1:0];
        dq_d = {dq_q[DW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obj_min_q <= OBJECT_MIN_RST;
      hand_min_q <= HAND_MIN_RST;
      h_cnt_q <= '0;
      h_sx_q <= '0;
      h_sy_q <= '0;
      h_sd_q <= '0;
      o_cnt_q <= '0;
      o_sx_q <= '0;
      o_sy_q <= '0;
      o_sd_q <= '0;
      hcx_q <= '0;
      hcy_q <= '0;
      hd_q <= '0;
      ocx_q <= '0;
      ocy_q <= '0;
      od_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_OBJECT_MIN: obj_min_q <= cfg_data_i;
          REG_HAND_MIN:   hand_min_q <= cfg_data_i;
          default: ;
        endcase
      end
      h_cnt_q <= h_cnt_d;
      h_sx_q <= h_sx_d;
      h_sy_q <= h_sy_d;
      h_sd_q <= h_sd_d;
      o_cnt_q <= o_cnt_d;
      o_sx_q <= o_sx_d;
      o_sy_q <= o_sy_d;
      o_sd_q <= o_sd_d;
      if (cmd_i.result_store) begin
        case (cmd_i.div_sel)
          SEL_HAND_X: if (hand_found) hcx_q <= dq_q[CXY_W-1:0];
          SEL_HAND_Y: if (hand_found) hcy_q <= dq_q[CXY_W-1:0];
          SEL_HAND_D: if (hand_found) hd_q <= dq_q[DEP_W-1:0];
          SEL_OBJ_X:  if (obj_found) ocx_q <= dq_q[CXY_W-1:0];
          SEL_OBJ_Y:  if (obj_found) ocy_q <= dq_q[CXY_W-1:0];
          SEL_OBJ_D:  if (obj_found) od_q <= dq_q[DEP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    if (cmd_i.out_load) begin
      out_q.hand_found <= hand_found;
      out_q.hand_cx <= hcx_q;
      out_q.hand_cy <= hcy_q;
      out_q.hand_depth <= hd_q;
      out_q.object_found <= obj_found;
      out_q.object_cx <= ocx_q;
      out_q.object_cy <= ocy_q;
      out_q.object_depth <= od_q;
    end
  end

  assign out_word_o = out_q;

  a_acc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> (h_cnt_q == '0 && o_cnt_q == '0))
    else $error("accumulators not cleared after result");

  a_counts_hold_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |=> ($stable(h_cnt_q) && $stable(o_cnt_q)))
    else $error("counts changed during division");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.div_step && dvs_q != '0) |=> (rem_q < dvs_q))
    else $error("division remainder out of range");

endmodule

[rtl/masked_centroid_depth.sv]
// ----------------------------------------------------------------------------
// masked_centroid_depth
// Per-frame centroid and mean depth of the hand and object pixel classes.
// ----------------------------------------------------------------------------
// Input channel: one pixel word per accepted cycle (valid high, stall low).
// Object wins over hand. Pixels are taken at one per clock while a frame
// accumulates; frame_first restarts the sums, frame_last closes the frame.
// After a frame_last word the input stalls while one shared restoring
// divider runs six divisions (x, y and depth of each class), one quotient
// bit per cycle, each giving DW quotient bits, with DW = max(COORD_BITS + 24,
// DEPTH_BITS + 20), 36 at the default widths. That divider sets the
// per-frame cost.
// Output channel: one result word per frame, held in an output register.
// A stalled result keeps its word; pixels of the next frame are still taken,
// and only the next frame's result waits for the register to free.
// Configuration: write thresholds with cfg_we_i while the block is idle.
// Reset: thresholds return to 20 and 50, sums and held centroids clear,
// no word is pending.
// ----------------------------------------------------------------------------
module masked_centroid_depth #(
  parameter int COORD_BITS = mcd_pkg::COORD_BITS_DEF,
  parameter int DEPTH_BITS = mcd_pkg::DEPTH_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mcd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mcd_pkg::CNT_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  mcd_pkg::pixel_t               in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mcd_pkg::result_t              out_word_o
);
  import mcd_pkg::*;

  cmd_t cmd;

  mcd_ctrl #(
    .COORD_BITS(COORD_BITS),
    .DEPTH_BITS(DEPTH_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_word_i.frame_last),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd)
  );

  mcd_datapath #(
    .COORD_BITS(COORD_BITS),
    .DEPTH_BITS(DEPTH_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_word_i (in_word_i),
    .cmd_i     (cmd),
    .out_word_o(out_word_o)
  );

endmodule
